// ===== rtl/core/ssrt_pkg.sv =====
// Shared types and codes for the session slot roster table.
`default_nettype none
package ssrt_pkg;

  // Operation codes carried in cmd_t.kind
  localparam logic [2:0] KIND_ADMIT      = 3'd0;
  localparam logic [2:0] KIND_ADMIT_JOIN = 3'd1;
  localparam logic [2:0] KIND_START      = 3'd2;
  localparam logic [2:0] KIND_REMOVE     = 3'd3;
  localparam logic [2:0] KIND_HOLD       = 3'd4;
  localparam logic [2:0] KIND_RELEASE    = 3'd5;
  localparam logic [2:0] KIND_QUERY      = 3'd6;

  // Result status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_BAD_SLOT    = 2'd1;
  localparam logic [1:0] STATUS_NOT_JOINING = 2'd2;
  localparam logic [1:0] STATUS_FULL        = 2'd3;

  // Slot value meaning "no slot"
  localparam logic [3:0] NO_SLOT = 4'd8;

  // Reset value of the slot count register
  localparam logic [3:0] SLOT_COUNT_RESET = 4'd8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] peer_id;
    logic [2:0]  slot_number;
    logic        spectator;
    logic [63:0] reconnect_token;
    logic [31:0] frame_number;
    logic [63:0] time_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_member;
    logic        is_joining;
    logic [3:0]  member_slot;
    logic [63:0] member_token;
    logic [3:0]  free_slot;
    logic [7:0]  slots_in_play;
    logic [7:0]  slots_awaited;
    logic        table_empty;
  } result_t;

  // One roster entry as stored in the table memory
  typedef struct packed {
    logic [31:0] peer;
    logic [3:0]  slot;
    logic        joining;
    logic [31:0] start_frame;
    logic [63:0] token;
    logic        held;
    logic [63:0] deadline;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/ssrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ssrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/session_slot_roster_table.sv =====
// Top level of the session slot roster table.
`default_nettype none
// Member roster kept in admission order in a single-port-per-direction RAM,
// compacted on removal so members always sit at positions 0 .. count-1.
// A command is taken when start is high and busy is low; busy then stays high
// until the result is shown. The result is presented for exactly one cycle
// with done high and must be captured then, since the receiver cannot stall
// it. Every command walks the occupied entries once, one RAM read per cycle.
// The walk gathers slot, in-play and held masks and the first entry of the
// peer; remove and release held rewrite kept entries downward in the same
// walk. No clearing pass is needed after reset: the member count marks which
// entries are live. The slot count register may be written at any time the
// block is idle; cfg_ready is always high.
module session_slot_roster_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int MAX_SLOTS   = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire ssrt_pkg::cmd_t   cmd,
  output logic                  done,
  output ssrt_pkg::result_t     result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [3:0]       cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam logic [NW-1:0] DEPTH_N   = NW'(TABLE_DEPTH);
  localparam logic [3:0]    MAX_SLOTS_W = 4'(MAX_SLOTS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0] state;
  logic [3:0] slot_count;
  logic [NW-1:0] count;

  ssrt_pkg::cmd_t cur;

  // Walk pointers: read index, write index for compaction
  logic [NW-1:0] rd_ptr;
  logic [NW-1:0] wr_ptr;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;

  // Accumulated over kept entries
  logic [7:0] taken;
  logic [7:0] in_play;
  logic [7:0] held_mask;
  logic       found;
  logic [AW-1:0] found_idx;
  ssrt_pkg::entry_t found_e;

  // RAM ports
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  ssrt_pkg::entry_t ram_wdata;
  ssrt_pkg::entry_t ram_rdata;
  logic [AW-1:0]    ram_raddr;

  logic [3:0] eff_slots;
  logic       compact_kind;
  logic       issue_rd;

  // Per-entry evaluation during the walk
  logic       drop;
  logic       has_slot;
  logic [7:0] ent_bit;

  // Apply-stage results
  logic [1:0]       ap_status;
  logic             ap_we;
  logic [AW-1:0]    ap_waddr;
  ssrt_pkg::entry_t ap_wdata;
  logic [NW-1:0]    ap_count;
  logic [7:0]       ap_taken;
  logic [7:0]       ap_in_play;
  logic [7:0]       ap_held;
  logic             ap_found;
  logic             ap_joining;
  logic [3:0]       ap_slot;
  logic [63:0]      ap_token;
  logic [3:0]       ap_free;
  logic [3:0]       req_slot;
  logic             bad_slot;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign eff_slots    = (slot_count > MAX_SLOTS_W) ? MAX_SLOTS_W : slot_count;
  assign compact_kind = (cur.kind == ssrt_pkg::KIND_REMOVE) ||
                        (cur.kind == ssrt_pkg::KIND_RELEASE);
  assign issue_rd     = (state == ST_SCAN) && (rd_ptr < count);
  assign ram_raddr    = rd_ptr[AW-1:0];

  ssrt_ram #(
    .WIDTH ($bits(ssrt_pkg::entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry read back this cycle: removal test and mask contribution
  always_comb begin
    drop = ((cur.kind == ssrt_pkg::KIND_REMOVE) && (ram_rdata.peer == cur.peer_id)) ||
           ((cur.kind == ssrt_pkg::KIND_RELEASE) && ram_rdata.held &&
            (ram_rdata.deadline <= cur.time_value));
    has_slot = (ram_rdata.slot < MAX_SLOTS_W);
    ent_bit  = 8'(1) << ram_rdata.slot[2:0];
  end

  // Operation applied after the walk
  always_comb begin
    ap_status  = ssrt_pkg::STATUS_OK;
    ap_we      = 1'b0;
    ap_waddr   = found_idx;
    ap_wdata   = found_e;
    ap_count   = compact_kind ? wr_ptr : count;
    ap_taken   = taken;
    ap_in_play = in_play;
    ap_held    = held_mask;
    ap_found   = found;
    ap_joining = found_e.joining;
    ap_slot    = found_e.slot;
    ap_token   = found_e.token;
    req_slot   = ((cur.kind == ssrt_pkg::KIND_ADMIT) && cur.spectator) ?
                 ssrt_pkg::NO_SLOT : {1'b0, cur.slot_number};
    bad_slot   = (req_slot != ssrt_pkg::NO_SLOT) &&
                 ((req_slot >= eff_slots) || taken[req_slot[2:0]]);
    case (cur.kind)
      ssrt_pkg::KIND_ADMIT, ssrt_pkg::KIND_ADMIT_JOIN: begin
        if (bad_slot) begin
          ap_status = ssrt_pkg::STATUS_BAD_SLOT;
        end else if (count >= DEPTH_N) begin
          ap_status = ssrt_pkg::STATUS_FULL;
        end else begin
          ap_we                = 1'b1;
          ap_waddr             = count[AW-1:0];
          ap_wdata.peer        = cur.peer_id;
          ap_wdata.slot        = req_slot;
          ap_wdata.joining     = (cur.kind == ssrt_pkg::KIND_ADMIT_JOIN);
          ap_wdata.start_frame = '0;
          ap_wdata.token       = cur.reconnect_token;
          ap_wdata.held        = 1'b0;
          ap_wdata.deadline    = '0;
          ap_count             = count + NW'(1);
          if (req_slot != ssrt_pkg::NO_SLOT) begin
            ap_taken = taken | (8'(1) << req_slot[2:0]);
            if (cur.kind == ssrt_pkg::KIND_ADMIT) begin
              ap_in_play = in_play | (8'(1) << req_slot[2:0]);
            end
          end
          if (!found) begin
            ap_found   = 1'b1;
            ap_joining = (cur.kind == ssrt_pkg::KIND_ADMIT_JOIN);
            ap_slot    = req_slot;
            ap_token   = cur.reconnect_token;
          end
        end
      end
      ssrt_pkg::KIND_START: begin
        if (!found || !found_e.joining) begin
          ap_status = ssrt_pkg::STATUS_NOT_JOINING;
        end else begin
          ap_we                = 1'b1;
          ap_wdata.joining     = 1'b0;
          ap_wdata.start_frame = cur.frame_number;
          ap_joining           = 1'b0;
          if (found_e.slot < MAX_SLOTS_W) begin
            ap_in_play = in_play | (8'(1) << found_e.slot[2:0]);
          end
        end
      end
      ssrt_pkg::KIND_HOLD: begin
        if (found) begin
          ap_we             = 1'b1;
          ap_wdata.held     = 1'b1;
          ap_wdata.deadline = cur.time_value;
          if (found_e.slot < MAX_SLOTS_W) begin
            ap_held = held_mask | (8'(1) << found_e.slot[2:0]);
          end
        end
      end
      default: begin
      end
    endcase
    // Lowest free slot below the effective count
    ap_free = ssrt_pkg::NO_SLOT;
    for (int s = 7; s >= 0; s--) begin
      if ((4'(s) < eff_slots) && !ap_taken[s]) begin
        ap_free = 4'(s);
      end
    end
  end

  // RAM write: kept entries move down during the walk, one update at apply
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_ptr[AW-1:0];
    ram_wdata = ram_rdata;
    if (state == ST_SCAN) begin
      ram_we = rd_vld && !drop && compact_kind;
    end else if (state == ST_APPLY) begin
      ram_we    = ap_we;
      ram_waddr = ap_waddr;
      ram_wdata = ap_wdata;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= ssrt_pkg::SLOT_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slot_count <= cfg_data;
    end
  end

  // Sequencer and walk accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      done   <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            cur       <= cmd;
            rd_ptr    <= '0;
            wr_ptr    <= '0;
            rd_vld    <= 1'b0;
            taken     <= '0;
            in_play   <= '0;
            held_mask <= '0;
            found     <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_vld <= issue_rd;
          rd_idx <= rd_ptr[AW-1:0];
          if (issue_rd) begin
            rd_ptr <= rd_ptr + NW'(1);
          end
          if (rd_vld && !drop) begin
            if (compact_kind) begin
              wr_ptr <= wr_ptr + NW'(1);
            end
            if (has_slot) begin
              taken <= taken | ent_bit;
              if (!ram_rdata.joining && (ram_rdata.start_frame <= cur.frame_number)) begin
                in_play <= in_play | ent_bit;
              end
              if (ram_rdata.held) begin
                held_mask <= held_mask | ent_bit;
              end
            end
            if (!found && (ram_rdata.peer == cur.peer_id)) begin
              found     <= 1'b1;
              found_e   <= ram_rdata;
              found_idx <= rd_idx;
            end
          end
          if (!issue_rd && !rd_vld) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          count                <= ap_count;
          done                 <= 1'b1;
          result.status        <= ap_status;
          result.is_member     <= ap_found;
          result.is_joining    <= ap_found && ap_joining;
          result.member_slot   <= ap_found ? ap_slot : ssrt_pkg::NO_SLOT;
          result.member_token  <= ap_found ? ap_token : 64'd0;
          result.free_slot     <= ap_free;
          result.slots_in_play <= ap_in_play;
          result.slots_awaited <= ap_in_play & ~ap_held;
          result.table_empty   <= (ap_count == '0);
          state                <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
